// File: rtl/mpu_pkg.sv
package mpu_pkg;

  // default operand width
  localparam int MPU_WIDTH_DEF = 16;

endpackage

// File: rtl/mpu_if.sv
// valid/ready channel carrying one operand triple
interface mpu_in_if #(
  parameter int WIDTH = mpu_pkg::MPU_WIDTH_DEF
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] exponent;
  logic [WIDTH-1:0] base;

  modport source (output valid, output modulus, output exponent, output base, input ready);
  modport sink   (input valid, input modulus, input exponent, input base, output ready);
endinterface

// valid/ready channel carrying one result word
interface mpu_out_if #(
  parameter int WIDTH = mpu_pkg::MPU_WIDTH_DEF
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] residue;
  logic             is_unity;

  modport source (output valid, output residue, output is_unity, input ready);
  modport sink   (input valid, input residue, input is_unity, output ready);
endinterface

// File: rtl/mpu_mulmod.sv
module mpu_mulmod #(
  parameter int WIDTH = mpu_pkg::MPU_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] prod
);
  import mpu_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;
  logic [WIDTH-1:0] r_r, r_nxt;

  logic [WIDTH:0]   dbl, dred, sum, sred;

  // one interleaved step: r = (2r + a_bit * b) mod m, operands below m
  always_comb begin
    dbl  = {r_r, 1'b0};
    dred = (dbl >= {1'b0, m_r}) ? (dbl - {1'b0, m_r}) : dbl;
    sum  = {1'b0, dred[WIDTH-1:0]} + (a_r[WIDTH-1] ? {1'b0, b_r} : '0);
    sred = (sum >= {1'b0, m_r}) ? (sum - {1'b0, m_r}) : sum;
  end

  // step sequencing, msb of a first
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    r_nxt    = r_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(WIDTH);
      a_nxt    = a;
      b_nxt    = b;
      m_nxt    = m;
      r_nxt    = '0;
    end else if (busy_r) begin
      r_nxt   = sred[WIDTH-1:0];
      a_nxt   = {a_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    m_r <= m_nxt;
    r_r <= r_nxt;
  end

  assign done = done_r;
  assign prod = r_r;

endmodule

// File: rtl/modular_power_unity_check_unit.sv
// after a word is accepted the base is reduced by a multiply unless the modulus is zero, then each
// exponent bit up to the top set one takes a check step, a multiply when set and a squaring
// below the top bit, and a last step loads the output word
// throughput: one word at a time, the next word is taken the cycle after the result loads
// reset (synchronous, active low) returns the sequencer to idle and drops the result valid
module modular_power_unity_check_unit #(
  parameter int WIDTH = mpu_pkg::MPU_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mpu_in_if.sink    in_ch,
  mpu_out_if.source out_ch
);
  import mpu_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RED  = 6'b000010,
    ST_CHK  = 6'b000100,
    ST_MACC = 6'b001000,
    ST_MSQ  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;
  logic [WIDTH-1:0] e_r, e_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] sq_r, sq_nxt;
  logic             ov_r, ov_nxt;
  logic [WIDTH-1:0] ores_r, ores_nxt;
  logic             oone_r, oone_nxt;

  logic             mul_start;
  logic [WIDTH-1:0] mul_a, mul_b, mul_m;
  logic             mul_done;
  logic [WIDTH-1:0] mul_p;
  logic             in_take;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid && (state_r == ST_IDLE);

  // shared modular multiplier
  mpu_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (mul_m),
    .done  (mul_done),
    .prod  (mul_p)
  );

  // sequencer: reduce base, then square-and-multiply lsb first
  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    e_nxt     = e_r;
    acc_nxt   = acc_r;
    sq_nxt    = sq_r;
    ov_nxt    = ov_r;
    ores_nxt  = ores_r;
    oone_nxt  = oone_r;
    mul_start = 1'b0;
    mul_a     = sq_r;
    mul_b     = sq_r;
    mul_m     = m_r;

    if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          m_nxt   = in_ch.modulus;
          e_nxt   = in_ch.exponent;
          acc_nxt = (in_ch.modulus > WIDTH'(1)) ? WIDTH'(1) : '0;
          if (in_ch.modulus == '0) begin
            e_nxt     = '0;
            state_nxt = ST_OUT;
          end else begin
            // base mod m as base * 1
            mul_start = 1'b1;
            mul_a     = in_ch.base;
            mul_b     = WIDTH'(1);
            mul_m     = in_ch.modulus;
            state_nxt = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (mul_done) begin
          sq_nxt    = mul_p;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (e_r == '0) begin
          state_nxt = ST_OUT;
        end else if (e_r[0]) begin
          mul_start = 1'b1;
          mul_a     = acc_r;
          state_nxt = ST_MACC;
        end else begin
          mul_start = 1'b1;
          state_nxt = ST_MSQ;
        end
      end
      ST_MACC: begin
        if (mul_done) begin
          acc_nxt = mul_p;
          if (e_r[WIDTH-1:1] == '0) begin
            // no higher bits left, skip the squaring
            e_nxt     = '0;
            state_nxt = ST_OUT;
          end else begin
            mul_start = 1'b1;
            state_nxt = ST_MSQ;
          end
        end
      end
      ST_MSQ: begin
        if (mul_done) begin
          sq_nxt    = mul_p;
          e_nxt     = {1'b0, e_r[WIDTH-1:1]};
          state_nxt = ST_CHK;
        end
      end
      ST_OUT: begin
        // load the output word once the slot is free
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          ores_nxt  = acc_r;
          oone_nxt  = (acc_r == WIDTH'(1));
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    m_r    <= m_nxt;
    e_r    <= e_nxt;
    acc_r  <= acc_nxt;
    sq_r   <= sq_nxt;
    ores_r <= ores_nxt;
    oone_r <= oone_nxt;
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.residue  = ores_r;
  assign out_ch.is_unity = oone_r;

endmodule

// File: verif/modular_power_unity_check_unit_test.sv
`timescale 1ns / 100ps

module modular_power_unity_check_unit_test;

  localparam int W           = mpu_pkg::MPU_WIDTH_DEF;
  localparam int NUM_TABLE   = 22;
  localparam int NUM_RANDOM  = 528;
  localparam int DRAIN_WAIT  = 600;

  typedef struct packed {
    logic [W-1:0] residue;
    logic         is_unity;
  } power_result_t;

  typedef struct packed {
    logic [W-1:0]  modulus;
    logic [W-1:0]  exponent;
    logic [W-1:0]  base;
    logic          typed;
    power_result_t result;
  } triple_row_t;

  logic clk = 1'b0;
  logic rst_n;

  mpu_in_if  #(.WIDTH(W)) in_ch ();
  mpu_out_if #(.WIDTH(W)) out_ch ();

  modular_power_unity_check_unit #(.WIDTH(W)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // free-running clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  power_result_t pending_results[$];
  power_result_t oldest_result;
  triple_row_t   triple_tbl [NUM_TABLE];
  int            error_cnt = 0;
  int            send_idle_pct;
  int            recv_idle_pct;

  // square-and-multiply with a reduction after every product
  function automatic power_result_t power_residue(input logic [W-1:0] m,
                                                  input logic [W-1:0] e,
                                                  input logic [W-1:0] b);
    logic [2*W-1:0] acc;
    logic [2*W-1:0] sq;
    power_result_t  r;
    if (m == '0) begin
      r.residue  = '0;
      r.is_unity = 1'b0;
      return r;
    end
    acc = (2*W)'(1) % (2*W)'(m);
    sq  = (2*W)'(b) % (2*W)'(m);
    for (int i = 0; i < W; i++) begin
      if (e[i]) begin
        acc = (acc * sq) % m;
      end
      sq = (sq * sq) % m;
    end
    r.residue  = acc[W-1:0];
    r.is_unity = (acc == 1);
    return r;
  endfunction

  // drive one operand word, keep valid high into the next word when there is no gap
  task automatic send_triple(input logic [W-1:0] m, input logic [W-1:0] e,
                             input logic [W-1:0] b, input power_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.modulus  <= m;
    in_ch.exponent <= e;
    in_ch.base     <= b;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    pending_results.push_back(res);
  endtask

  // receiver stall
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result word: residue %h is_unity %b", $time,
                 out_ch.residue, out_ch.is_unity);
        error_cnt++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_ch.residue !== oldest_result.residue) begin
          $display("%0t residue mismatch: expected %h actual %h", $time,
                   oldest_result.residue, out_ch.residue);
          error_cnt++;
        end
        if (out_ch.is_unity !== oldest_result.is_unity) begin
          $display("%0t is_unity mismatch: expected %b actual %b", $time,
                   oldest_result.is_unity, out_ch.is_unity);
          error_cnt++;
        end
      end
    end
  end

  // main sequence
  initial begin
    logic [W-1:0] m;
    logic [W-1:0] e;
    logic [W-1:0] b;
    int           sel;

    send_idle_pct   = 38;
    recv_idle_pct   = 84;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.modulus  <= '0;
    in_ch.exponent <= '0;
    in_ch.base     <= '0;

    // modulus, exponent, base, typed, {residue, is_unity}
    triple_tbl = '{
      // modulus of one always reduces to zero
      '{16'd1,     16'd1,     16'd0,     1'b1, '{16'd0,     1'b0}},
      '{16'd1,     16'hffff,  16'hffff,  1'b1, '{16'd0,     1'b0}},
      '{16'd1,     16'd0,     16'd5,     1'b1, '{16'd0,     1'b0}},
      // modulus of zero gives zero
      '{16'd0,     16'd5,     16'd7,     1'b1, '{16'd0,     1'b0}},
      '{16'd0,     16'hffff,  16'hffff,  1'b1, '{16'd0,     1'b0}},
      // exponent of zero gives the empty product
      '{16'd7,     16'd0,     16'd3,     1'b1, '{16'd1,     1'b1}},
      '{16'hffff,  16'd0,     16'hffff,  1'b1, '{16'd1,     1'b1}},
      // base extremes
      '{16'hffff,  16'd1,     16'd0,     1'b1, '{16'd0,     1'b0}},
      '{16'hffff,  16'hffff,  16'd1,     1'b1, '{16'd1,     1'b1}},
      '{16'hffff,  16'd1,     16'hffff,  1'b1, '{16'd0,     1'b0}},
      '{16'hffff,  16'hffff,  16'hffff,  1'b1, '{16'd0,     1'b0}},
      '{16'hffff,  16'd1,     16'hfffe,  1'b1, '{16'hfffe,  1'b0}},
      '{16'hffff,  16'd2,     16'hfffe,  1'b1, '{16'd1,     1'b1}},
      '{16'd2,     16'hffff,  16'd3,     1'b1, '{16'd1,     1'b1}},
      // the rest go through the predictor
      '{16'd65521, 16'd65520, 16'd3,     1'b0, '{16'd0,     1'b0}},
      '{16'd65521, 16'd32760, 16'd17,    1'b0, '{16'd0,     1'b0}},
      '{16'hffff,  16'hffff,  16'd12345, 1'b0, '{16'd0,     1'b0}},
      '{16'hfffe,  16'h8000,  16'hfffd,  1'b0, '{16'd0,     1'b0}},
      '{16'h8000,  16'h5555,  16'haaaa,  1'b0, '{16'd0,     1'b0}},
      '{16'h5555,  16'haaaa,  16'hffff,  1'b0, '{16'd0,     1'b0}},
      '{16'd13,    16'd12,    16'd2,     1'b0, '{16'd0,     1'b0}},
      '{16'd257,   16'd256,   16'd3,     1'b0, '{16'd0,     1'b0}}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (triple_tbl[i]) begin
      send_triple(triple_tbl[i].modulus, triple_tbl[i].exponent, triple_tbl[i].base,
                  triple_tbl[i].typed ? triple_tbl[i].result :
                  power_residue(triple_tbl[i].modulus, triple_tbl[i].exponent,
                                triple_tbl[i].base));
    end

    // random words in three idling phases
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) begin
        send_idle_pct = 84;
        recv_idle_pct = 38;
      end else if (n == 2 * NUM_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      sel = $urandom_range(99);
      if (sel < 4) begin
        m = '0;
      end else if (sel < 8) begin
        m = W'(1);
      end else if (sel < 20) begin
        m = W'($urandom_range(255, 2));
      end else if (sel < 30) begin
        m = W'($urandom_range(65535, 65000));
      end else begin
        m = W'($urandom_range(65535, 2));
      end
      sel = $urandom_range(99);
      if (sel < 4) begin
        e = '0;
      end else if (sel < 25) begin
        e = W'($urandom_range(15, 1));
      end else begin
        e = W'($urandom);
      end
      // sometimes a base below the modulus, mostly any value
      if (m != '0 && $urandom_range(99) < 30) begin
        b = W'($urandom % m);
      end else begin
        b = W'($urandom);
      end
      send_triple(m, e, b, power_residue(m, e, b));
    end
    in_ch.valid <= 1'b0;

    // drain
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_cnt == 0) begin
      $display("[modular_power_unity_check_unit] OK");
    end else begin
      $display("[modular_power_unity_check_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("[modular_power_unity_check_unit] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/mpu_pkg.sv
rtl/mpu_if.sv
rtl/mpu_mulmod.sv
rtl/modular_power_unity_check_unit.sv
verif/modular_power_unity_check_unit_test.sv
